/* rtl/pdt_pkg.sv */
// Shared types, constants and register codes for the prescaled down counter timer.
package pdt_pkg;

   localparam int COUNTER_WIDTH = 32;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [2:0] REG_LOAD   = 3'd0;
   localparam logic [2:0] REG_VALUE  = 3'd1;
   localparam logic [2:0] REG_CTRL   = 3'd2;
   localparam logic [2:0] REG_INTCLR = 3'd3;
   localparam logic [2:0] REG_RIS    = 3'd4;
   localparam logic [2:0] REG_MIS    = 3'd5;
   localparam logic [2:0] REG_BGLOAD = 3'd6;

   localparam int CTL_ONESHOT_BIT  = 0;
   localparam int CTL_SIZE32_BIT   = 1;
   localparam int CTL_PRE_LSB      = 2;
   localparam int CTL_INTEN_BIT    = 5;
   localparam int CTL_PERIODIC_BIT = 6;
   localparam int CTL_ENABLE_BIT   = 7;

   localparam logic [7:0] CTL_STORED = 8'hEF;
   localparam logic [7:0] CTL_RESET  = 8'h20;

   localparam logic [1:0] PRE_DIV1  = 2'd0;
   localparam logic [1:0] PRE_DIV16 = 2'd1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  reg_index;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq;
   } rsp_type;

endpackage

/* rtl/pdt_core.sv */
// Timer state registers, prescaler, counter step and register access decode.
module pdt_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  pdt_pkg::req_type req,
   output pdt_pkg::rsp_type rsp
);

   localparam int CW = pdt_pkg::COUNTER_WIDTH;

   logic [CW-1:0] reload_ff, reload_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    ctl_ff, ctl_in;
   logic          raw_ff, raw_in;
   logic [7:0]    pre_ff, pre_in;

   logic [CW-1:0] mask;
   logic [CW-1:0] c_cur;
   logic [CW-1:0] c_dec;
   logic [CW-1:0] c_wrap;
   logic [8:0]    pre_sum;
   logic [8:0]    period;
   logic [31:0]   rd;

   assign mask    = ctl_ff[pdt_pkg::CTL_SIZE32_BIT] ? '1 : CW'(16'hFFFF);
   assign c_cur   = count_ff & mask;
   assign c_dec   = (c_cur - CW'(1)) & mask;
   assign c_wrap  = ctl_ff[pdt_pkg::CTL_PERIODIC_BIT] ? (reload_ff & mask) : mask;
   assign pre_sum = {1'b0, pre_ff} + 9'd1;

   always_comb begin
      case (ctl_ff[pdt_pkg::CTL_PRE_LSB +: 2])
         pdt_pkg::PRE_DIV1:  period = 9'd1;
         pdt_pkg::PRE_DIV16: period = 9'd16;
         default:            period = 9'd256;
      endcase
   end

   always_comb begin
      reload_in = reload_ff;
      count_in  = count_ff;
      ctl_in    = ctl_ff;
      raw_in    = raw_ff;
      pre_in    = pre_ff;
      case (req.kind)
         pdt_pkg::KIND_TICK: begin
            if (ctl_ff[pdt_pkg::CTL_ENABLE_BIT]) begin
               if (pre_sum >= period) begin
                  pre_in = 8'd0;
                  if (c_cur != '0) begin
                     count_in = c_dec;
                     if (c_dec == '0) begin
                        raw_in = 1'b1;
                        if (ctl_ff[pdt_pkg::CTL_ONESHOT_BIT])
                           ctl_in[pdt_pkg::CTL_ENABLE_BIT] = 1'b0;
                     end
                  end else if (ctl_ff[pdt_pkg::CTL_ONESHOT_BIT]) begin
                     count_in = c_cur;
                     raw_in   = 1'b1;
                     ctl_in[pdt_pkg::CTL_ENABLE_BIT] = 1'b0;
                  end else begin
                     count_in = c_wrap;
                     if (c_wrap == '0)
                        raw_in = 1'b1;
                  end
               end else begin
                  pre_in = pre_sum[7:0];
               end
            end
         end
         pdt_pkg::KIND_WRITE: begin
            case (req.reg_index)
               pdt_pkg::REG_LOAD: begin
                  reload_in = req.write_data[CW-1:0];
                  count_in  = req.write_data[CW-1:0];
               end
               pdt_pkg::REG_CTRL:   ctl_in    = req.write_data[7:0] & pdt_pkg::CTL_STORED;
               pdt_pkg::REG_INTCLR: raw_in    = 1'b0;
               pdt_pkg::REG_BGLOAD: reload_in = req.write_data[CW-1:0];
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      rd = 32'd0;
      if (req.kind == pdt_pkg::KIND_READ) begin
         case (req.reg_index)
            pdt_pkg::REG_LOAD:   rd = 32'(reload_ff);
            pdt_pkg::REG_VALUE:  rd = 32'(count_ff);
            pdt_pkg::REG_CTRL:   rd = {24'd0, ctl_ff};
            pdt_pkg::REG_RIS:    rd = {31'd0, raw_ff};
            pdt_pkg::REG_MIS:    rd = {31'd0, raw_ff & ctl_ff[pdt_pkg::CTL_INTEN_BIT]};
            pdt_pkg::REG_BGLOAD: rd = 32'(reload_ff);
            default:             rd = 32'd0;
         endcase
      end
   end

   assign rsp.read_data = rd;
   assign rsp.irq       = raw_in & ctl_in[pdt_pkg::CTL_INTEN_BIT];

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= '0;
         count_ff  <= '1;
         ctl_ff    <= pdt_pkg::CTL_RESET;
         raw_ff    <= 1'b0;
         pre_ff    <= 8'd0;
      end else if (accept) begin
         reload_ff <= reload_in;
         count_ff  <= count_in;
         ctl_ff    <= ctl_in;
         raw_ff    <= raw_in;
         pre_ff    <= pre_in;
      end
   end

endmodule

/* rtl/pdt_out_reg.sv */
// Result register with valid/ready handshake toward the response channel.
module pdt_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  pdt_pkg::rsp_type rsp_next,
   output logic             in_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pdt_pkg::rsp_type rsp_payload
);

   logic             valid_ff, valid_in;
   pdt_pkg::rsp_type data_ff;

   assign in_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept)
         valid_in = 1'b1;
      else if (rsp_ready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept)
         data_ff <= rsp_next;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

/* rtl/prescaled_down_counter_timer_unit.sv */
// Top level of the prescaled down counter timer: one timer of a dual-timer pair.
//
// req channel: each transfer is a prescaled timer tick, a register write or a
// register read (kind, reg_index, write_data). rsp channel: one transfer per
// request, carrying read_data (zero unless a read) and irq, the masked
// interrupt after the request has taken effect.
// The timer state updates at the req transfer and the result sits in the
// output register from the next cycle. The unit takes one request per cycle
// while req_ready is high, as the counter/prescaler step is combinational.
// req_ready stays high while the output register is empty or being drained,
// so a stalled receiver holds one result and backpressures req after that.
// Reset (synchronous): load 0, counter all ones, control 0x20 (interrupt
// enabled, timer stopped), raw interrupt and prescaler cleared, no result
// pending.
module prescaled_down_counter_timer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pdt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pdt_pkg::rsp_type rsp_payload
);

   logic             accept;
   pdt_pkg::rsp_type rsp_next;

   assign accept = req_valid && req_ready;

   pdt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .rsp    (rsp_next)
   );

   pdt_out_reg u_out (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rsp_next    (rsp_next),
      .in_ready    (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
